// File: rtl/angle_bias_kalman_filter_macros.svh
// Assertion macros for the angle and bias Kalman filter.
// Used by the top level only; no other dependencies.
`ifndef ANGLE_BIAS_KALMAN_FILTER_MACROS_SVH
`define ANGLE_BIAS_KALMAN_FILTER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ABKF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ABKF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/abkf_pkg.sv
// Shared constants and fixed-point helpers for the angle and bias filter.
// No dependencies.
package abkf_pkg;

  localparam int unsigned QW = 32;
  localparam int unsigned FRAC = 16;
  localparam int unsigned IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_STEP    = 3'd0;
  localparam logic [IDX_W-1:0] REG_ANOISE  = 3'd1;
  localparam logic [IDX_W-1:0] REG_BNOISE  = 3'd2;
  localparam logic [IDX_W-1:0] REG_MNOISE  = 3'd3;
  localparam logic [IDX_W-1:0] REG_OBSERVE = 3'd4;

  localparam logic [15:0] STEP_RST = 16'd328;
  localparam logic [30:0] ANOISE_RST = 31'd66;
  localparam logic [30:0] BNOISE_RST = 31'd197;
  localparam logic [30:0] MNOISE_RST = 31'd32768;
  localparam logic signed [31:0] Q_ONE = 32'sd65536;

  // Saturate a 34-bit signed value into 32 bits.
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) r = 32'sh7fffffff;
    else if (v < -34'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Product shifted right by the fraction width (floor), saturated.
  function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
    logic signed [47:0] s;
    logic signed [31:0] r;
    s = p[63:16];
    if (s > 48'sd2147483647) r = 32'sh7fffffff;
    else if (s < -48'sd2147483648) r = 32'sh80000000;
    else r = s[31:0];
    return r;
  endfunction

endpackage

// File: rtl/angle_bias_kalman_filter.sv
// Two-state angle and gyro bias Kalman filter in signed Q16.16. A sequencer runs
// 31 operations through one shared multiply/add unit and, when the innovation
// variance is positive, two 48-step restoring divisions for the gains. The next
// sample is accepted on the cycle after the result transfer at the earliest.
// Input is not ready while a sample is in work or its result waits in the output
// register. Configuration writes are taken at any time and should only be issued
// while no sample is in work.
// Depends on abkf_pkg, abkf_alu, abkf_div and the assertion macro header.
`include "angle_bias_kalman_filter_macros.svh"
module angle_bias_kalman_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] accel_angle, [63:32] gyro_rate
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] filtered_angle, [63:32] corrected_rate
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  typedef enum logic [1:0] {S_IDLE, S_ALU, S_DIV, S_OUT} state_e;
  typedef logic signed [31:0] q_t;

  state_e state_q;
  logic [4:0] op_q;
  logic       ph_q;
  logic       dstart_q, dstart_d;
  logic       dsel_q;

  logic [15:0] step_q;
  logic [30:0] anoise_q, bnoise_q, mnoise_q;
  q_t obs_q;
  q_t ang_q, bias_q, p0_q, p1_q, p2_q, p3_q;
  q_t acc_q, gyr_q, t_q, d0_q, d12_q, pct0_q, pct1_q, e_q, k0_q, k1_q, err_q, t1_q;
  q_t rate_q;

  logic is_mul, sub;
  q_t a, b, c, y, quo;
  logic ddone;
  q_t dt;
  logic out_stall;

  assign dt = q_t'({16'd0, step_q});

  abkf_alu u_alu (.clk_i, .is_mul_i(is_mul), .sub_i(sub), .a_i(a), .b_i(b), .c_i(c), .y_o(y));
  abkf_div u_div (.clk_i, .rst_ni, .start_i(dstart_q), .num_i(dsel_q ? pct1_q : pct0_q),
                  .den_i(e_q), .done_o(ddone), .quo_o(quo));

  // Operation table: operands of each step; result written in the second phase.
  always_comb begin
    is_mul = 1'b1; sub = 1'b0; a = '0; b = '0; c = '0;
    case (op_q)
      5'd0:  begin is_mul = 1'b0; sub = 1'b1; a = gyr_q; b = bias_q; end
      5'd1:  begin a = t_q; b = dt; end
      5'd2:  begin is_mul = 1'b0; a = ang_q; b = t_q; end
      5'd3:  begin is_mul = 1'b0; sub = 1'b1; a = q_t'({1'b0, anoise_q}); b = p1_q; c = p2_q; end
      5'd4:  begin is_mul = 1'b0; sub = 1'b1; a = '0; b = p3_q; end
      5'd5:  begin a = d0_q; b = dt; end
      5'd6:  begin is_mul = 1'b0; a = p0_q; b = t_q; end
      5'd7:  begin a = d12_q; b = dt; end
      5'd8:  begin is_mul = 1'b0; a = p1_q; b = t_q; end
      5'd9:  begin is_mul = 1'b0; a = p2_q; b = t_q; end
      5'd10: begin a = q_t'({1'b0, bnoise_q}); b = dt; end
      5'd11: begin is_mul = 1'b0; a = p3_q; b = t_q; end
      5'd12: begin a = obs_q; b = p0_q; end
      5'd13: begin a = obs_q; b = p2_q; end
      5'd14: begin a = obs_q; b = pct0_q; end
      5'd15: begin is_mul = 1'b0; a = q_t'({1'b0, mnoise_q}); b = t_q; end
      5'd16: begin is_mul = 1'b0; sub = 1'b1; a = acc_q; b = ang_q; end
      5'd17: begin a = k0_q; b = err_q; end
      5'd18: begin is_mul = 1'b0; a = ang_q; b = t_q; end
      5'd19: begin a = k1_q; b = err_q; end
      5'd20: begin is_mul = 1'b0; a = bias_q; b = t_q; end
      5'd21: begin is_mul = 1'b0; sub = 1'b1; a = gyr_q; b = bias_q; end
      5'd22: begin a = obs_q; b = p1_q; end
      5'd23: begin a = k0_q; b = pct0_q; end
      5'd24: begin is_mul = 1'b0; sub = 1'b1; a = p0_q; b = t_q; end
      5'd25: begin a = k0_q; b = t1_q; end
      5'd26: begin is_mul = 1'b0; sub = 1'b1; a = p1_q; b = t_q; end
      5'd27: begin a = k1_q; b = pct0_q; end
      5'd28: begin is_mul = 1'b0; sub = 1'b1; a = p2_q; b = t_q; end
      5'd29: begin a = k1_q; b = t1_q; end
      5'd30: begin is_mul = 1'b0; sub = 1'b1; a = p3_q; b = t_q; end
      default: ;
    endcase
  end

  // The first division starts once a positive innovation variance is known, the
  // second as soon as the first quotient is handed back.
  assign dstart_d = (state_q == S_ALU && ph_q && op_q == 5'd15 && !y[31] && y != '0) ||
                    (state_q == S_DIV && ddone && !dsel_q);

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata = {rate_q, ang_q};
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; op_q <= '0; ph_q <= 1'b0; dstart_q <= 1'b0; dsel_q <= 1'b0;
      step_q <= abkf_pkg::STEP_RST; anoise_q <= abkf_pkg::ANOISE_RST;
      bnoise_q <= abkf_pkg::BNOISE_RST; mnoise_q <= abkf_pkg::MNOISE_RST;
      obs_q <= abkf_pkg::Q_ONE;
      ang_q <= '0; bias_q <= '0; p0_q <= abkf_pkg::Q_ONE; p1_q <= '0; p2_q <= '0;
      p3_q <= abkf_pkg::Q_ONE;
    end else begin
      dstart_q <= dstart_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          abkf_pkg::REG_STEP:    step_q <= cfg_data_i[15:0];
          abkf_pkg::REG_ANOISE:  anoise_q <= cfg_data_i[30:0];
          abkf_pkg::REG_BNOISE:  bnoise_q <= cfg_data_i[30:0];
          abkf_pkg::REG_MNOISE:  mnoise_q <= cfg_data_i[30:0];
          abkf_pkg::REG_OBSERVE: obs_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            state_q <= S_ALU; op_q <= '0; ph_q <= 1'b0;
          end
        end
        S_ALU: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            case (op_q)
              5'd2, 5'd18: ang_q <= y;
              5'd3:  d0_q <= y;
              5'd4:  d12_q <= y;
              5'd6, 5'd24: p0_q <= y;
              5'd8, 5'd26: p1_q <= y;
              5'd9, 5'd28: p2_q <= y;
              5'd11, 5'd30: p3_q <= y;
              5'd12: pct0_q <= y;
              5'd13: pct1_q <= y;
              5'd15: e_q <= y;
              5'd16: err_q <= y;
              5'd20: bias_q <= y;
              5'd21: rate_q <= y;
              5'd22: t1_q <= y;
              default: t_q <= y;
            endcase
            op_q <= op_q + 5'd1;
            if (op_q == 5'd15) begin
              if (!y[31] && y != '0) begin
                state_q <= S_DIV; dsel_q <= 1'b0;
              end else begin
                k0_q <= '0; k1_q <= '0;
              end
            end
            if (op_q == 5'd30) state_q <= S_OUT;
          end
        end
        S_DIV: begin
          if (ddone) begin
            if (!dsel_q) begin
              k0_q <= quo; dsel_q <= 1'b1;
            end else begin
              k1_q <= quo; state_q <= S_ALU; ph_q <= 1'b0;
            end
          end
        end
        S_OUT: if (m_axis_tready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && s_axis_tvalid) begin
      acc_q <= s_axis_tdata[31:0];
      gyr_q <= s_axis_tdata[63:32];
    end
  end

  `ABKF_ASSERT_IMP(a_out_no_in, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)
  `ABKF_ASSERT_NEXT(a_hold_out, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
  `ABKF_ASSERT_NEXT(a_take_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

// File: rtl/abkf_div.sv
// Restoring radix-2 divider for the gain computation: sat((num << 16) / den).
// No dependencies. Denominator is positive; quotient truncates toward zero.
module abkf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quo_o
);

  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        neg_q, neg_d;
  logic [47:0] dvd_q, dvd_d;
  logic [31:0] den_q, den_d;
  logic [32:0] rem_q, rem_d;
  logic [47:0] quo_q, quo_d;
  logic        done_q, done_d;
  logic [32:0] trial;
  logic [31:0] mag;

  always_comb begin
    mag = num_i[31] ? 32'(-num_i) : 32'(num_i);
    trial = {rem_q[31:0], dvd_q[47]} - {1'b0, den_q};
    busy_d = busy_q;
    cnt_d = cnt_q;
    neg_d = neg_q;
    dvd_d = dvd_q;
    den_d = den_q;
    rem_d = rem_q;
    quo_d = quo_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = 6'd0;
      neg_d = num_i[31];
      dvd_d = {mag, 16'd0};
      den_d = den_i;
      rem_d = '0;
      quo_d = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[46:0], 1'b0};
      if (!trial[32]) begin
        rem_d = trial;
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], dvd_q[47]};
        quo_d = {quo_q[46:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd47) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    dvd_q <= dvd_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  always_comb begin
    if (!neg_q) quo_o = (quo_q > 48'd2147483647) ? 32'sh7fffffff : quo_q[31:0];
    else quo_o = (quo_q > 48'd2147483648) ? 32'sh80000000 : 32'(-quo_q[31:0]);
  end
  assign done_o = done_q;

endmodule

// File: rtl/abkf_alu.sv
// Shared Q16.16 arithmetic unit: one registered multiply or saturating add/sub.
// Depends on abkf_pkg.
module abkf_alu (
  input  logic               clk_i,
  input  logic               is_mul_i,
  input  logic               sub_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  input  logic signed [31:0] c_i,
  output logic signed [31:0] y_o
);

  logic signed [63:0] prod;
  logic signed [33:0] sum;
  logic signed [31:0] y_q, y_d;

  // Add/sub takes three operands: a + b or a - b, then minus c.
  always_comb begin
    prod = a_i * b_i;
    if (sub_i) sum = 34'(a_i) - 34'(b_i) - 34'(c_i);
    else sum = 34'(a_i) + 34'(b_i) - 34'(c_i);
    y_d = is_mul_i ? abkf_pkg::qscale(prod) : abkf_pkg::sat34(sum);
  end

  always_ff @(posedge clk_i) y_q <= y_d;
  assign y_o = y_q;

endmodule
